### rtl/core/opl_csp_pkg.sv
package opl_csp_pkg;

    // Event kinds carried on m_tuser
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TEMPO = 2'd1;
    localparam logic [1:0] KIND_DELAY = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam int KIND_W        = 2;
    localparam int TICKS_W       = 24;
    localparam int CLOCK_W       = 16;
    localparam int OUT_DATA_W    = 64;
    localparam int DELAY_BITS_DEF = 24;

    // Register and value codes in the capture stream
    localparam logic [7:0] REG_DELAY   = 8'h00;
    localparam logic [7:0] REG_CONTROL = 8'h02;
    localparam logic [7:0] REG_END     = 8'hFF;
    localparam logic [7:0] CTRL_CLOCK  = 8'h00;
    localparam logic [7:0] CTRL_CHIP0  = 8'h01;
    localparam logic [7:0] CTRL_CHIP1  = 8'h02;
    localparam logic [7:0] VAL_END     = 8'hFF;
    localparam logic [15:0] CLOCK_ZERO_MAP = 16'hFFFF;

endpackage

### rtl/core/opl_capture_stream_parser_top.sv
// Parser for the event body of a raw OPL register capture. One byte is taken per
// request on the slave side (s_tlast marks end of stream, no byte then) and the
// block accepts a new request every cycle while s_tready is high; an event appears on
// the master side in the cycle after the request that completes it and is held in the
// output register until taken, with s_tready following m_tready only while that
// register is full. Delay pairs add into a sum of DELAY_BITS bits that saturates, and
// each event carries the pending sum (reported saturated to 24 bits), which is then
// cleared. After an end event all requests are consumed and ignored until reset.
module opl_capture_stream_parser_top #(
    parameter int DELAY_BITS = opl_csp_pkg::DELAY_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // stream_over
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] has_delay, [24:1] delay_ticks, [25] chip_select, [33:26] reg_address,
    // [41:34] reg_value, [57:42] clock_divisor, [63:58] zero
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser    // [1:0] event_kind
);

    localparam int EXT_W = (DELAY_BITS > opl_csp_pkg::TICKS_W) ? DELAY_BITS
                                                                : opl_csp_pkg::TICKS_W;

    typedef enum logic [2:0] {
        PH_VALUE,
        PH_REG,
        PH_CLK_LO,
        PH_CLK_HI,
        PH_DONE
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [7:0]              held_value_reg, held_value_next;
    logic [7:0]              clock_low_reg, clock_low_next;
    logic                    chip_reg, chip_next;
    logic [DELAY_BITS-1:0]   delay_sum_reg, delay_sum_next;
    logic                    delay_seen_reg, delay_seen_next;

    logic                    m_tvalid_reg;
    logic [63:0]             m_tdata_reg;
    logic [1:0]              m_tuser_reg;

    logic                    accept;
    logic                    emit;
    logic [1:0]              kind;
    logic                    ev_chip;
    logic [7:0]              ev_addr;
    logic [7:0]              ev_value;
    logic [15:0]             ev_clock;
    logic [15:0]             raw_clock;
    logic [DELAY_BITS:0]     sum_wide;
    logic [EXT_W-1:0]        sum_ext;
    logic [23:0]             ticks;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign sum_wide  = {1'b0, delay_sum_reg} + (DELAY_BITS + 1)'(held_value_reg);
    assign raw_clock = {s_tdata, clock_low_reg};
    assign sum_ext   = EXT_W'(delay_sum_reg);
    assign ticks     = (sum_ext > EXT_W'(24'hFFFFFF)) ? 24'hFFFFFF : sum_ext[23:0];

    always_comb
    begin
        phase_next      = phase_reg;
        held_value_next = held_value_reg;
        clock_low_next  = clock_low_reg;
        chip_next       = chip_reg;
        delay_sum_next  = delay_sum_reg;
        delay_seen_next = delay_seen_reg;
        emit            = 1'b0;
        kind            = opl_csp_pkg::KIND_DELAY;
        ev_chip         = 1'b0;
        ev_addr         = 8'd0;
        ev_value        = 8'd0;
        ev_clock        = 16'd0;

        if (accept && phase_reg != PH_DONE)
        begin
            if (s_tlast)
            begin
                phase_next = PH_DONE;
                emit       = 1'b1;
                kind       = opl_csp_pkg::KIND_END;
            end
            else
            begin
                case (phase_reg)
                    PH_VALUE:
                    begin
                        held_value_next = s_tdata;
                        phase_next      = PH_REG;
                    end
                    PH_CLK_LO:
                    begin
                        clock_low_next = s_tdata;
                        phase_next     = PH_CLK_HI;
                    end
                    PH_CLK_HI:
                    begin
                        phase_next = PH_VALUE;
                        emit       = 1'b1;
                        kind       = opl_csp_pkg::KIND_TEMPO;
                        ev_clock   = (raw_clock == 16'd0) ? opl_csp_pkg::CLOCK_ZERO_MAP
                                                          : raw_clock;
                    end
                    PH_REG:
                    begin
                        phase_next = PH_VALUE;
                        if (s_tdata == opl_csp_pkg::REG_DELAY)
                        begin
                            // saturate on carry out of the sum
                            delay_sum_next  = sum_wide[DELAY_BITS] ? '1
                                                                   : sum_wide[DELAY_BITS-1:0];
                            delay_seen_next = 1'b1;
                        end
                        else if (s_tdata == opl_csp_pkg::REG_CONTROL)
                        begin
                            if (held_value_reg == opl_csp_pkg::CTRL_CLOCK)
                                phase_next = PH_CLK_LO;
                            else if (held_value_reg == opl_csp_pkg::CTRL_CHIP0)
                                chip_next = 1'b0;
                            else if (held_value_reg == opl_csp_pkg::CTRL_CHIP1)
                                chip_next = 1'b1;
                            else
                            begin
                                emit = 1'b1;
                                kind = opl_csp_pkg::KIND_DELAY;
                            end
                        end
                        else if (s_tdata == opl_csp_pkg::REG_END)
                        begin
                            emit = 1'b1;
                            if (held_value_reg == opl_csp_pkg::VAL_END)
                            begin
                                phase_next = PH_DONE;
                                kind       = opl_csp_pkg::KIND_END;
                            end
                            else
                                kind = opl_csp_pkg::KIND_DELAY;
                        end
                        else
                        begin
                            emit     = 1'b1;
                            kind     = opl_csp_pkg::KIND_WRITE;
                            ev_chip  = chip_reg;
                            ev_addr  = s_tdata;
                            ev_value = held_value_reg;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end

            if (emit)
            begin
                delay_sum_next  = '0;
                delay_seen_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_VALUE;
            held_value_reg <= 8'd0;
            clock_low_reg  <= 8'd0;
            chip_reg       <= 1'b0;
            delay_sum_reg  <= '0;
            delay_seen_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_value_reg <= held_value_next;
            clock_low_reg  <= clock_low_next;
            chip_reg       <= chip_next;
            delay_sum_reg  <= delay_sum_next;
            delay_seen_reg <= delay_seen_next;
            if (emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_tuser_reg <= kind;
            m_tdata_reg <= {6'd0, ev_clock, ev_value, ev_addr, ev_chip, ticks,
                            delay_seen_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/core/opl_csp_checker.sv
module opl_csp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    logic end_sent_reg;

    // set once an end event has been taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            end_sent_reg <= 1'b0;
        else if (m_tvalid && m_tready && m_tuser == opl_csp_pkg::KIND_END)
            end_sent_reg <= 1'b1;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        end_sent_reg |-> !m_tvalid)
        else $error("event after end of data");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != opl_csp_pkg::KIND_WRITE) |->
            (m_tdata[41:25] == 17'd0))
        else $error("write fields set on a non-write event");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[24:1] == 24'd0))
        else $error("delay ticks without a delay pair");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == opl_csp_pkg::KIND_TEMPO) == (m_tdata[57:42] != 16'd0)))
        else $error("clock divisor does not match event kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled event changed");

endmodule

bind opl_capture_stream_parser_top opl_csp_checker u_opl_csp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
